FILE: hdl/lfk_pkg.sv
// Shared types, constants and fixed-point helpers for the leg pose pipeline.
// No dependencies; used by every lfk_* module and the top level.
`default_nettype none
package lfk_pkg;

    typedef logic signed [31:0] ent_t;
    typedef ent_t mat_t [3][3];
    typedef logic signed [63:0] prod_t;
    typedef logic signed [19:0] cfg_t;
    typedef logic signed [23:0] pos_t;
    typedef pos_t pos_vec_t [3];
    typedef logic signed [51:0] tprod_t;
    typedef logic signed [33:0] cw_t;
    typedef logic signed [34:0] vw_t;
    typedef logic signed [65:0] mprod_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        REG_HIP_X   = 3'd0,
        REG_HIP_Y   = 3'd1,
        REG_HIP_Z   = 3'd2,
        REG_KNEE_X  = 3'd3,
        REG_KNEE_Z  = 3'd4,
        REG_ANKLE_X = 3'd5,
        REG_ANKLE_Z = 3'd6,
        REG_SOLE_Z  = 3'd7
    } reg_idx_t;

    localparam int NUM_REGS     = 8;
    localparam int CORDIC_STEPS = 30;
    localparam int PIPE_DEPTH   = 105;

    localparam ent_t Q30_ONE    = 32'sd1073741824;
    localparam ent_t GAIN_INV   = 32'sd652032874;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    localparam cfg_t CFG_RESET [NUM_REGS] = '{
        20'sd0, 20'sd3277, -20'sd8651, 20'sd0,
        -20'sd9044, 20'sd0, -20'sd9372, -20'sd2621
    };

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // round half up from q60 to q30, then clamp to plus or minus one
    function automatic ent_t rnd_q30(input prod_t v);
        prod_t t;
        t = (v + 64'sd536870912) >>> 30;
        if (t > 64'sd1073741824) begin
            t = 64'sd1073741824;
        end else if (t < -64'sd1073741824) begin
            t = -64'sd1073741824;
        end
        return ent_t'(t);
    endfunction

    function automatic logic [15:0] angle_out(input logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h0000_8000;
        return t[31:16];
    endfunction

    function automatic logic signed [19:0] sat_pos(input pos_t v);
        logic signed [19:0] r;
        if (v > 24'sd524287) begin
            r = 20'sh7FFFF;
        end else if (v < -24'sd524288) begin
            r = 20'sh80000;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/lfk_sincos.sv
// Pipelined rotation-mode cordic lane: cosine and sine of one joint angle.
// Depends on lfk_pkg; 32 register stages.
`default_nettype none
module lfk_sincos (
    input  wire                 aclk,
    input  wire                 en,
    input  wire  [15:0]         ang,
    output lfk_pkg::ent_t       cos_out,
    output lfk_pkg::ent_t       sin_out
);

    localparam lfk_pkg::cw_t Q30  = 34'sd1073741824;
    localparam lfk_pkg::cw_t HALF = 34'sd2147483648;

    lfk_pkg::cw_t x_reg [lfk_pkg::CORDIC_STEPS+1];
    lfk_pkg::cw_t y_reg [lfk_pkg::CORDIC_STEPS+1];
    lfk_pkg::cw_t z_reg [lfk_pkg::CORDIC_STEPS+1];
    logic [lfk_pkg::CORDIC_STEPS:0] neg_reg;

    lfk_pkg::cw_t z_next;
    logic         neg_next;
    lfk_pkg::cw_t xf, yf;
    lfk_pkg::ent_t cos_reg, sin_reg;

    // fold into the right half plane
    always_comb begin
        z_next   = lfk_pkg::cw_t'($signed({ang, 16'h0000}));
        neg_next = 1'b0;
        if (z_next > Q30) begin
            z_next   = z_next - HALF;
            neg_next = 1'b1;
        end else if (z_next < -Q30) begin
            z_next   = z_next + HALF;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= lfk_pkg::cw_t'(lfk_pkg::GAIN_INV);
            y_reg[0]   <= '0;
            z_reg[0]   <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < lfk_pkg::CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - lfk_pkg::cw_t'(lfk_pkg::ATAN_TAB[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + lfk_pkg::cw_t'(lfk_pkg::ATAN_TAB[i]);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_comb begin
        xf = neg_reg[lfk_pkg::CORDIC_STEPS] ? -x_reg[lfk_pkg::CORDIC_STEPS]
                                            :  x_reg[lfk_pkg::CORDIC_STEPS];
        yf = neg_reg[lfk_pkg::CORDIC_STEPS] ? -y_reg[lfk_pkg::CORDIC_STEPS]
                                            :  y_reg[lfk_pkg::CORDIC_STEPS];
        if (xf > Q30) begin
            xf = Q30;
        end else if (xf < -Q30) begin
            xf = -Q30;
        end
        if (yf > Q30) begin
            yf = Q30;
        end else if (yf < -Q30) begin
            yf = -Q30;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= lfk_pkg::ent_t'(xf);
            sin_reg <= lfk_pkg::ent_t'(yf);
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule
`default_nettype wire

FILE: hdl/lfk_vec.sv
// Pipelined vectoring-mode cordic lane: angle and scaled length of a vector.
// Depends on lfk_pkg; 31 register stages.
`default_nettype none
module lfk_vec (
    input  wire                 aclk,
    input  wire                 en,
    input  var lfk_pkg::ent_t   x_in,
    input  var lfk_pkg::ent_t   y_in,
    output logic [31:0]         ang_out,
    output lfk_pkg::vw_t        mag_out
);

    lfk_pkg::vw_t x_reg [lfk_pkg::CORDIC_STEPS+1];
    lfk_pkg::vw_t y_reg [lfk_pkg::CORDIC_STEPS+1];
    logic [31:0]  z_reg [lfk_pkg::CORDIC_STEPS+1];
    logic [lfk_pkg::CORDIC_STEPS:0] zero_reg;

    lfk_pkg::vw_t x_next, y_next;
    logic [31:0]  z_next;

    // left half plane turned by a half turn first
    always_comb begin
        x_next = lfk_pkg::vw_t'(x_in);
        y_next = lfk_pkg::vw_t'(y_in);
        z_next = '0;
        if (x_in < 0) begin
            x_next = -x_next;
            y_next = -y_next;
            z_next = lfk_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    for (genvar i = 0; i < lfk_pkg::CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + lfk_pkg::ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - lfk_pkg::ATAN_TAB[i];
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign ang_out = zero_reg[lfk_pkg::CORDIC_STEPS] ? '0 : z_reg[lfk_pkg::CORDIC_STEPS];
    assign mag_out = x_reg[lfk_pkg::CORDIC_STEPS];

endmodule
`default_nettype wire

FILE: hdl/lfk_rot.sv
// One joint rotation applied to the running rotation matrix, two stages:
// products, then sum with rounding and clamp. Depends on lfk_pkg.
`default_nettype none
module lfk_rot (
    input  wire                 aclk,
    input  wire                 en,
    input  var lfk_pkg::axis_t  axis,
    input  var lfk_pkg::mat_t   r_in,
    input  var lfk_pkg::ent_t   c_in,
    input  var lfk_pkg::ent_t   s_in,
    output lfk_pkg::mat_t       r_out
);

    logic [1:0] ia, ib, ik;

    lfk_pkg::prod_t pac_reg [3];
    lfk_pkg::prod_t pbs_reg [3];
    lfk_pkg::prod_t pbc_reg [3];
    lfk_pkg::prod_t pas_reg [3];
    lfk_pkg::ent_t  keep_reg [3];
    lfk_pkg::mat_t  r_next;
    lfk_pkg::mat_t  r_reg;

    // column pair turned by the rotation, third column passes
    always_comb begin
        case (axis)
            lfk_pkg::AXIS_X: begin
                ia = 2'd1; ib = 2'd2; ik = 2'd0;
            end
            lfk_pkg::AXIS_Y: begin
                ia = 2'd2; ib = 2'd0; ik = 2'd1;
            end
            default: begin
                ia = 2'd0; ib = 2'd1; ik = 2'd2;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pac_reg[i]  <= lfk_pkg::prod_t'(r_in[i][ia]) * lfk_pkg::prod_t'(c_in);
                pbs_reg[i]  <= lfk_pkg::prod_t'(r_in[i][ib]) * lfk_pkg::prod_t'(s_in);
                pbc_reg[i]  <= lfk_pkg::prod_t'(r_in[i][ib]) * lfk_pkg::prod_t'(c_in);
                pas_reg[i]  <= lfk_pkg::prod_t'(r_in[i][ia]) * lfk_pkg::prod_t'(s_in);
                keep_reg[i] <= r_in[i][ik];
            end
        end
    end

    always_comb begin
        r_next = '{default: '0};
        for (int i = 0; i < 3; i++) begin
            r_next[i][ia] = lfk_pkg::rnd_q30(pac_reg[i] + pbs_reg[i]);
            r_next[i][ib] = lfk_pkg::rnd_q30(pbc_reg[i] - pas_reg[i]);
            r_next[i][ik] = keep_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    assign r_out = r_reg;

endmodule
`default_nettype wire

FILE: hdl/lfk_trans.sv
// Link translation: adds R*t, rounded from q46 to q16, to the position.
// Two stages: products, then sum. Depends on lfk_pkg.
`default_nettype none
module lfk_trans (
    input  wire                  aclk,
    input  wire                  en,
    input  var lfk_pkg::mat_t    r_in,
    input  var lfk_pkg::cfg_t    tx,
    input  var lfk_pkg::cfg_t    tz,
    input  var lfk_pkg::pos_vec_t p_in,
    output lfk_pkg::pos_vec_t    p_out
);

    lfk_pkg::tprod_t  m0_reg [3];
    lfk_pkg::tprod_t  m2_reg [3];
    lfk_pkg::pos_vec_t p_s_reg;
    lfk_pkg::pos_vec_t p_reg;
    lfk_pkg::tprod_t  sum [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m0_reg[i] <= lfk_pkg::tprod_t'(r_in[i][0]) * lfk_pkg::tprod_t'(tx);
                m2_reg[i] <= lfk_pkg::tprod_t'(r_in[i][2]) * lfk_pkg::tprod_t'(tz);
            end
            p_s_reg <= p_in;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = (m0_reg[i] + m2_reg[i] + 52'sd536870912) >>> 30;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= p_s_reg[i] + lfk_pkg::pos_t'(sum[i]);
            end
        end
    end

    assign p_out = p_reg;

endmodule
`default_nettype wire

FILE: hdl/leg_forward_kinematics_pose.sv
// Leg sole pose from six joint angles: six sin/cos cordic lanes, a rotation
// and translation chain, and three vectoring lanes for yaw, roll and pitch.
// One pose per cycle while the output is not stalled, set by the fully
// pipelined cordic lanes. The whole pipe stalls only while the output
// register holds an untaken result. Reset clears valid bits and loads the
// default link offsets. Depends on lfk_pkg and the lfk_* modules.
`default_nettype none
module leg_forward_kinematics_pose (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // hip yaw, hip roll, hip pitch, knee pitch, ankle pitch, ankle roll
    input  wire  [95:0]  s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // sole_x, sole_y, sole_z, sole_yaw, sole_pitch, sole_roll, zero pad
    output logic [111:0] m_tdata,
    input  wire          cfg_wr_en,
    input  wire  [2:0]   cfg_wr_addr,
    input  wire  [19:0]  cfg_wr_data
);

    logic en;
    logic [lfk_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic m_tvalid_reg;
    logic [107:0] out_data_reg;

    lfk_pkg::cfg_t cfg_reg [lfk_pkg::NUM_REGS];

    lfk_pkg::ent_t cos0 [6];
    lfk_pkg::ent_t sin0 [6];
    lfk_pkg::ent_t cos_d_reg [1:8][6];
    lfk_pkg::ent_t sin_d_reg [1:8][6];

    lfk_pkg::mat_t r0, r1, r2, r3, r4, r5;
    lfk_pkg::pos_vec_t p0, p1, p2, p3;
    lfk_pkg::pos_vec_t p2_d_reg [2];
    lfk_pkg::pos_vec_t p3_d_reg [61];

    logic [31:0]   yaw_ang, roll_ang, pitch_ang;
    lfk_pkg::vw_t  yaw_mag, roll_mag, pitch_mag;
    logic [31:0]   yaw_d_reg [32];
    logic [31:0]   roll_d_reg [32];
    lfk_pkg::ent_t r20_d_reg [32];
    lfk_pkg::mprod_t mag_prod_reg;
    lfk_pkg::mprod_t norm_sum;
    lfk_pkg::ent_t norm;
    lfk_pkg::ent_t pitch_y;
    logic [107:0]  out_data_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= lfk_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_wr_addr] <= $signed(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[lfk_pkg::PIPE_DEPTH-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[lfk_pkg::PIPE_DEPTH-1];
        end
    end

    for (genvar l = 0; l < 6; l++) begin : g_lane
        lfk_sincos u_sincos (
            .aclk    (aclk),
            .en      (en),
            .ang     (s_tdata[16*l +: 16]),
            .cos_out (cos0[l]),
            .sin_out (sin0[l])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_d_reg[1] <= cos0;
            sin_d_reg[1] <= sin0;
            for (int k = 2; k <= 8; k++) begin
                cos_d_reg[k] <= cos_d_reg[k-1];
                sin_d_reg[k] <= sin_d_reg[k-1];
            end
        end
    end

    // hip yaw applied to identity
    always_comb begin
        r0[0][0] = cos0[0];
        r0[0][1] = -sin0[0];
        r0[0][2] = '0;
        r0[1][0] = sin0[0];
        r0[1][1] = cos0[0];
        r0[1][2] = '0;
        r0[2][0] = '0;
        r0[2][1] = '0;
        r0[2][2] = lfk_pkg::Q30_ONE;
    end

    always_comb begin
        p0[0] = lfk_pkg::pos_t'(cfg_reg[lfk_pkg::REG_HIP_X]);
        p0[1] = lfk_pkg::pos_t'(cfg_reg[lfk_pkg::REG_HIP_Y]);
        p0[2] = lfk_pkg::pos_t'(cfg_reg[lfk_pkg::REG_HIP_Z]);
    end

    lfk_rot u_rot_j1 (
        .aclk (aclk), .en (en), .axis (lfk_pkg::AXIS_X), .r_in (r0),
        .c_in (cos0[1]), .s_in (sin0[1]), .r_out (r1)
    );

    lfk_rot u_rot_j2 (
        .aclk (aclk), .en (en), .axis (lfk_pkg::AXIS_Y), .r_in (r1),
        .c_in (cos_d_reg[2][2]), .s_in (sin_d_reg[2][2]), .r_out (r2)
    );

    lfk_trans u_trans_knee (
        .aclk (aclk), .en (en), .r_in (r2),
        .tx (cfg_reg[lfk_pkg::REG_KNEE_X]), .tz (cfg_reg[lfk_pkg::REG_KNEE_Z]),
        .p_in (p0), .p_out (p1)
    );

    lfk_rot u_rot_j3 (
        .aclk (aclk), .en (en), .axis (lfk_pkg::AXIS_Y), .r_in (r2),
        .c_in (cos_d_reg[4][3]), .s_in (sin_d_reg[4][3]), .r_out (r3)
    );

    lfk_trans u_trans_ankle (
        .aclk (aclk), .en (en), .r_in (r3),
        .tx (cfg_reg[lfk_pkg::REG_ANKLE_X]), .tz (cfg_reg[lfk_pkg::REG_ANKLE_Z]),
        .p_in (p1), .p_out (p2)
    );

    lfk_rot u_rot_j4 (
        .aclk (aclk), .en (en), .axis (lfk_pkg::AXIS_Y), .r_in (r3),
        .c_in (cos_d_reg[6][4]), .s_in (sin_d_reg[6][4]), .r_out (r4)
    );

    lfk_rot u_rot_j5 (
        .aclk (aclk), .en (en), .axis (lfk_pkg::AXIS_X), .r_in (r4),
        .c_in (cos_d_reg[8][5]), .s_in (sin_d_reg[8][5]), .r_out (r5)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_d_reg[0] <= p2;
            p2_d_reg[1] <= p2_d_reg[0];
        end
    end

    lfk_trans u_trans_sole (
        .aclk (aclk), .en (en), .r_in (r5),
        .tx ('0), .tz (cfg_reg[lfk_pkg::REG_SOLE_Z]),
        .p_in (p2_d_reg[1]), .p_out (p3)
    );

    lfk_vec u_vec_yaw (
        .aclk (aclk), .en (en), .x_in (r5[0][0]), .y_in (r5[1][0]),
        .ang_out (yaw_ang), .mag_out (yaw_mag)
    );

    lfk_vec u_vec_roll (
        .aclk (aclk), .en (en), .x_in (r5[2][2]), .y_in (r5[2][1]),
        .ang_out (roll_ang), .mag_out (roll_mag)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            r20_d_reg[0]  <= r5[2][0];
            yaw_d_reg[0]  <= yaw_ang;
            roll_d_reg[0] <= roll_ang;
            p3_d_reg[0]   <= p3;
            for (int k = 1; k < 32; k++) begin
                r20_d_reg[k]  <= r20_d_reg[k-1];
                yaw_d_reg[k]  <= yaw_d_reg[k-1];
                roll_d_reg[k] <= roll_d_reg[k-1];
            end
            for (int k = 1; k < 61; k++) begin
                p3_d_reg[k] <= p3_d_reg[k-1];
            end
            mag_prod_reg <= lfk_pkg::mprod_t'(roll_mag) *
                            lfk_pkg::mprod_t'(lfk_pkg::GAIN_INV);
        end
    end

    // norm of row 2 entries 1 and 2, gain removed
    assign norm_sum = (mag_prod_reg + 66'sd536870912) >>> 30;
    assign norm     = lfk_pkg::ent_t'(norm_sum);
    assign pitch_y  = -r20_d_reg[31];

    lfk_vec u_vec_pitch (
        .aclk (aclk), .en (en), .x_in (norm), .y_in (pitch_y),
        .ang_out (pitch_ang), .mag_out (pitch_mag)
    );

    always_comb begin
        out_data_next = {
            lfk_pkg::angle_out(roll_d_reg[31]),
            lfk_pkg::angle_out(pitch_ang),
            lfk_pkg::angle_out(yaw_d_reg[31]),
            lfk_pkg::sat_pos(p3_d_reg[60][2]),
            lfk_pkg::sat_pos(p3_d_reg[60][1]),
            lfk_pkg::sat_pos(p3_d_reg[60][0])
        };
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    // vector lengths are never negative
    a_pitch_mag_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[lfk_pkg::PIPE_DEPTH-1] |-> (pitch_mag >= 0))
        else $error("pitch vector length negative");

    a_yaw_mag_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[72] |-> (yaw_mag >= 0))
        else $error("yaw vector length negative");

    a_stall_freezes : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    a_r5_range : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[41] |-> (r5[2][0] <= lfk_pkg::Q30_ONE && r5[2][0] >= -lfk_pkg::Q30_ONE))
        else $error("rotation entry out of range");

    a_pitch_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($signed(out_data_reg[91:76]) <= 16'sd16384 &&
                          $signed(out_data_reg[91:76]) >= -16'sd16384))
        else $error("pitch outside quarter turn");

endmodule
`default_nettype wire
